@@ hw/rtl/prc_pkg.sv @@
// Shared types and constants for the polyline rectangle clipper.
// No dependencies; every other file of the block uses it.
package prc_pkg;

	localparam int CoordW  = 16;
	localparam int CfgIdxW = 2;
	localparam int QuotW   = 17;
	localparam int NumW    = 37;
	localparam int DenW    = 18;

	typedef logic signed [CoordW-1:0] coord_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_XMIN = 2'd0,
		REG_YMIN = 2'd1,
		REG_XMAX = 2'd2,
		REG_YMAX = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic   start;
		coord_t a0;
		coord_t b0;
		coord_t a1;
		coord_t b1;
		coord_t e;
	} ip_req_t;

	typedef struct packed {
		logic   busy;
		logic   done;
		coord_t q;
	} ip_status_t;

endpackage

@@ hw/rtl/prc_if.sv @@
// Valid/ready channel interfaces for vertex words in and clipped vertex words out.
// Depends on prc_pkg.
interface prc_in_if;
	logic            valid;
	logic            ready;
	prc_pkg::coord_t px;
	prc_pkg::coord_t py;
	logic            line_start;
	logic            new_collection;
	modport source (output valid, px, py, line_start, new_collection, input ready);
	modport sink (input valid, px, py, line_start, new_collection, output ready);
endinterface

interface prc_out_if;
	logic            valid;
	logic            ready;
	prc_pkg::coord_t qx;
	prc_pkg::coord_t qy;
	logic            begins_line;
	logic            last;
	modport source (output valid, qx, qy, begins_line, last, input ready);
	modport sink (input valid, qx, qy, begins_line, last, output ready);
endinterface

@@ hw/rtl/prc_divider.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on prc_pkg. The caller guarantees the quotient fits QuotW bits.
module prc_divider (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [prc_pkg::NumW-1:0]     num,
	input  logic [prc_pkg::DenW-1:0]     den,
	output logic                         done,
	output logic [prc_pkg::QuotW-1:0]    quot
);
	localparam int RemW = prc_pkg::DenW + 1;
	localparam int CntW = $clog2(prc_pkg::QuotW + 1);

	logic [RemW-1:0]            rem_q;
	logic [prc_pkg::QuotW-1:0]  qs_q;
	logic [prc_pkg::DenW-1:0]   den_q;
	logic [CntW-1:0]            cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [RemW-1:0]            trial;
	logic                       ge;

	// Shift the next dividend bit into the partial remainder.
	assign trial = {rem_q[RemW-2:0], qs_q[prc_pkg::QuotW-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(prc_pkg::QuotW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// The high part is below the divisor, so it starts as the remainder.
			rem_q <= num[prc_pkg::NumW-2 -: RemW];
			qs_q  <= num[prc_pkg::QuotW-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? trial - {1'b0, den_q} : trial;
			qs_q  <= {qs_q[prc_pkg::QuotW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = qs_q;
endmodule

@@ hw/rtl/prc_interp.sv @@
// Edge interpolation: forms the exact numerator with two multiplies, then divides
// serially with rounding half away from zero. Depends on prc_pkg and prc_divider.
module prc_interp (
	input  logic                clk,
	input  logic                arst_n,
	input  prc_pkg::ip_req_t    req,
	output prc_pkg::ip_status_t status
);
	typedef enum logic [2:0] {
		S_IDLE, S_MUL0, S_MUL1, S_SUM, S_PREP, S_DIV, S_DONE
	} ip_state_t;

	ip_state_t state_q;
	prc_pkg::coord_t a0_q, b0_q, a1_q, b1_q, e_q, q_q;
	logic signed [16:0] d_q, de_q, db_q;
	logic signed [32:0] p0_q;
	logic signed [35:0] n_q;
	logic [prc_pkg::NumW-1:0] num_q;
	logic [prc_pkg::DenW-1:0] den_q;
	logic sgn_q, zero_q, div_start_q, done_q;
	logic div_done;
	logic [prc_pkg::QuotW-1:0] quot;
	logic signed [35:0] nn;
	logic [35:0] mag;
	logic [16:0] dd;
	logic signed [33:0] p1;

	assign nn  = d_q[16] ? -n_q : n_q;
	assign mag = nn[35] ? 36'(-nn) : 36'(nn);
	assign dd  = d_q[16] ? 17'(-d_q) : 17'(d_q);

	// Second product is added in the cycle after the first is registered.
	assign p1 = 34'(db_q) * 34'(de_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_start_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			done_q      <= 1'b0;
			case (state_q)
				S_IDLE: if (req.start) state_q <= S_MUL0;
				S_MUL0: state_q <= S_MUL1;
				S_MUL1: state_q <= S_SUM;
				S_SUM: state_q <= S_PREP;
				S_PREP: begin
					div_start_q <= !zero_q;
					state_q     <= zero_q ? S_DONE : S_DIV;
				end
				S_DIV: if (div_done) state_q <= S_DONE;
				S_DONE: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				a0_q <= req.a0;
				b0_q <= req.b0;
				a1_q <= req.a1;
				b1_q <= req.b1;
				e_q  <= req.e;
			end
			S_MUL0: begin
				d_q  <= 17'(a1_q) - 17'(a0_q);
				de_q <= 17'(e_q) - 17'(a0_q);
				db_q <= 17'(b1_q) - 17'(b0_q);
			end
			S_MUL1: begin
				p0_q   <= 33'(b0_q) * 33'(d_q);
				zero_q <= d_q == '0;
			end
			S_SUM: n_q <= 36'(p0_q) + 36'(p1);
			S_PREP: ;
			S_DIV: ;
			S_DONE: ;
			default: ;
		endcase
		if (state_q == S_PREP) begin
			sgn_q <= nn[35];
			// round(n/d) = floor((2|n| + d) / 2d)
			num_q <= {mag, 1'b0} + prc_pkg::NumW'(dd);
			den_q <= {dd, 1'b0};
		end
		if (state_q == S_DIV && div_done)
			q_q <= sgn_q ? 16'(-quot) : 16'(quot);
		if (state_q == S_PREP && zero_q)
			q_q <= b0_q;
	end

	prc_divider u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start_q),
		.num   (num_q),
		.den   (den_q),
		.done  (div_done),
		.quot  (quot)
	);

	assign status.busy = state_q != S_IDLE;
	assign status.done = done_q;
	assign status.q    = q_q;
endmodule

@@ hw/rtl/polyline_rect_clipper.sv @@
// Top level of the polyline rectangle clipper: registers, clip sequencer, output word.
// Depends on prc_pkg, prc_if and prc_interp.
//
//  channel | dir | fields
//  in_ch   | in  | px, py, line_start, new_collection
//  out_ch  | out | qx, qy, begins_line, last
//  cfg     | in  | cfg_we, cfg_idx, cfg_data
//
// A vertex that opens a line is only stored as the previous point; a segment runs one
// test per edge, and a clipped edge adds its interpolation (four setup steps, a serial
// divide of the 17-bit quotient and the hand-back).
// Output words leave through one register; while it is full and the sink stalls,
// the sequencer waits before loading the next word. Reset restores the edges to
// 0/4096 and clears all history.
module polyline_rect_clipper (
	input  logic                          clk,
	input  logic                          arst_n,
	prc_in_if.sink                        in_ch,
	prc_out_if.source                     out_ch,
	input  logic                          cfg_we,
	input  logic [prc_pkg::CfgIdxW-1:0]   cfg_idx,
	input  logic [prc_pkg::CoordW-1:0]    cfg_data
);
	typedef enum logic [2:0] {S_IDLE, S_EDGE, S_WAIT, S_PUT0, S_PUT1} st_t;

	st_t state_q;
	prc_pkg::coord_t xmin_q, ymin_q, xmax_q, ymax_q;
	prc_pkg::coord_t prev_x_q, prev_y_q, lox_q, loy_q;
	prc_pkg::coord_t x0_q, y0_q, x1_q, y1_q;
	prc_pkg::coord_t qx_q, qy_q;
	logic have_prev_q, have_out_q, ovalid_q, obeg_q, olast_q, side_q;
	logic [1:0] edge_q;
	prc_pkg::ip_req_t    ip_req;
	prc_pkg::ip_status_t ip_st;
	logic acc, out0, out1, can_load, skip0, oload;
	prc_pkg::coord_t ea0, eb0, ea1, eb1, ee;

	assign acc      = in_ch.valid && in_ch.ready;
	assign can_load = !ovalid_q || out_ch.ready;
	// A start point equal to the last emitted point continues the output line.
	assign skip0    = have_out_q && x0_q == lox_q && y0_q == loy_q;
	assign oload    = can_load && ((state_q == S_PUT0 && !skip0) || state_q == S_PUT1);

	// Odd edges clip in y, so the roles of x and y swap.
	always_comb begin
		ea0 = edge_q[0] ? y0_q : x0_q;
		eb0 = edge_q[0] ? x0_q : y0_q;
		ea1 = edge_q[0] ? y1_q : x1_q;
		eb1 = edge_q[0] ? x1_q : y1_q;
		case (edge_q)
			2'd0: ee = xmin_q;
			2'd1: ee = ymin_q;
			2'd2: ee = xmax_q;
			default: ee = ymax_q;
		endcase
		out0 = edge_q[1] ? (ea0 >= ee) : (ea0 < ee);
		out1 = edge_q[1] ? (ea1 >= ee) : (ea1 < ee);
	end

	assign ip_req.start = state_q == S_EDGE && (out0 ^ out1);
	assign ip_req.a0 = ea0;
	assign ip_req.b0 = eb0;
	assign ip_req.a1 = ea1;
	assign ip_req.b1 = eb1;
	assign ip_req.e  = ee;

	prc_interp u_interp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (ip_req),
		.status(ip_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			xmin_q      <= '0;
			ymin_q      <= '0;
			xmax_q      <= 16'sd4096;
			ymax_q      <= 16'sd4096;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			lox_q       <= '0;
			loy_q       <= '0;
			have_prev_q <= 1'b0;
			have_out_q  <= 1'b0;
			ovalid_q    <= 1'b0;
			edge_q      <= '0;
			side_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (prc_pkg::cfg_reg_t'(cfg_idx))
					prc_pkg::REG_XMIN: xmin_q <= cfg_data;
					prc_pkg::REG_YMIN: ymin_q <= cfg_data;
					prc_pkg::REG_XMAX: xmax_q <= cfg_data;
					prc_pkg::REG_YMAX: ymax_q <= cfg_data;
					default: ;
				endcase
			end
			if (oload) ovalid_q <= 1'b1;
			else if (out_ch.ready) ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (acc) begin
					prev_x_q    <= in_ch.px;
					prev_y_q    <= in_ch.py;
					have_prev_q <= 1'b1;
					if (in_ch.new_collection) have_out_q <= 1'b0;
					x0_q   <= prev_x_q;
					y0_q   <= prev_y_q;
					x1_q   <= in_ch.px;
					y1_q   <= in_ch.py;
					edge_q <= '0;
					if (have_prev_q && !in_ch.line_start && !in_ch.new_collection)
						state_q <= S_EDGE;
				end
				S_EDGE: begin
					side_q <= out1;
					if (out0 && out1) begin
						state_q <= S_IDLE;
					end else if (out0 || out1) begin
						state_q <= S_WAIT;
					end else begin
						edge_q <= edge_q + 1'b1;
						if (edge_q == 2'd3) state_q <= S_PUT0;
					end
				end
				S_WAIT: if (ip_st.done) begin
					// Move the outside endpoint onto the edge.
					if (side_q) begin
						if (edge_q[0]) begin
							x1_q <= ip_st.q;
							y1_q <= ee;
						end else begin
							y1_q <= ip_st.q;
							x1_q <= ee;
						end
					end else begin
						if (edge_q[0]) begin
							x0_q <= ip_st.q;
							y0_q <= ee;
						end else begin
							y0_q <= ip_st.q;
							x0_q <= ee;
						end
					end
					edge_q  <= edge_q + 1'b1;
					state_q <= edge_q == 2'd3 ? S_PUT0 : S_EDGE;
				end
				S_PUT0: begin
					if (skip0) begin
						state_q <= S_PUT1;
					end else if (can_load) begin
						qx_q     <= x0_q;
						qy_q     <= y0_q;
						obeg_q   <= 1'b1;
						olast_q  <= 1'b0;
						state_q  <= S_PUT1;
					end
				end
				S_PUT1: if (can_load) begin
					qx_q       <= x1_q;
					qy_q       <= y1_q;
					obeg_q     <= 1'b0;
					olast_q    <= 1'b1;
					lox_q      <= x1_q;
					loy_q      <= y1_q;
					have_out_q <= 1'b1;
					state_q    <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ch.ready        = state_q == S_IDLE;
	assign out_ch.valid       = ovalid_q;
	assign out_ch.qx          = qx_q;
	assign out_ch.qy          = qy_q;
	assign out_ch.begins_line = obeg_q;
	assign out_ch.last        = olast_q;

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		ip_st.done |-> state_q == S_WAIT)
		else $error("interpolation finished outside the wait state");
	a_idle_unit_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !ip_st.busy)
		else $error("interpolator busy while the sequencer is idle");
	a_end_sets_history: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUT1 && can_load) |=> have_out_q && ovalid_q && olast_q)
		else $error("end point emitted without recording output history");
endmodule
